### rtl/gtr_pkg.sv
// Shared definitions for the glyph text renderer: field widths, register
// indexes and reset values, action codes and the sequencer state type.
// No dependencies.
package gtr_pkg;

  // Default sizing of the glyph store and of the cursor
  localparam int GTR_GLYPH_COUNT    = 256;
  localparam int GTR_MAX_GLYPH_ROWS = 8;
  localparam int GTR_COORD_BITS     = 12;

  // Port field widths
  localparam int ACTION_W   = 2;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 3;
  localparam int BITS_W     = 8;
  localparam int NEWXY_W    = 12;
  localparam int OFFSET_W   = 27;
  localparam int VALUE_W    = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register widths
  localparam int PITCH_W  = 14;
  localparam int BPP_W    = 3;
  localparam int GDIM_W   = 4;
  localparam int MARGIN_W = 12;
  localparam int STEP_W   = 8;

  // Widest glyph the column scan handles
  localparam int GLYPH_COLS = 8;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_DRAW   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CURSOR = 2'd2;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ADVANCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_ADVANCE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR   = 3'd7;

  // Register reset values
  localparam logic [PITCH_W-1:0]  RST_ROW_PITCH    = 14'd3840;
  localparam logic [BPP_W-1:0]    RST_BYTES_PER_PX = 3'd2;
  localparam logic [GDIM_W-1:0]   RST_GLYPH_WIDTH  = 4'd8;
  localparam logic [GDIM_W-1:0]   RST_GLYPH_HEIGHT = 4'd8;
  localparam logic [MARGIN_W-1:0] RST_LEFT_MARGIN  = 12'd20;
  localparam logic [STEP_W-1:0]   RST_LINE_ADVANCE = 8'd10;
  localparam logic [STEP_W-1:0]   RST_CHAR_ADVANCE = 8'd8;
  localparam logic [VALUE_W-1:0]  RST_DRAW_COLOR   = 16'hffff;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### rtl/glyph_text_renderer_top.sv
// Glyph text renderer top level: glyph store loading, cursor control and
// expansion of glyph rows into framebuffer pixel writes.
// Depends on gtr_pkg and gtr_ram.
//
//  channel  | signals                           | beat carries
//  ---------+-----------------------------------+---------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | one action: draw, load, cursor
//  output   | m_tvalid m_tready m_tdata m_tlast | one pixel write, tlast on final
//  config   | cfg_we cfg_index cfg_data         | one register write
//
// Load, cursor and newline beats, and draws that cannot start, finish as accepted. A draw
// reads each glyph row from the RAM, then emits a pixel for each set bit and closes the
// row, and a closing state ends each glyph before the next beat is accepted. The single
// RAM read port and one pixel per cycle while the output does not stall set the draw time.
// Reset clears the cursor, registers and control, not the glyph RAM. A stalled output
// holds the scan; input is taken only when idle.
module glyph_text_renderer_top
  import gtr_pkg::*;
#(
  parameter int GLYPH_COUNT    = GTR_GLYPH_COUNT,
  parameter int MAX_GLYPH_ROWS = GTR_MAX_GLYPH_ROWS,
  parameter int COORD_BITS     = GTR_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // char_code[7:0], row_index[10:8], row_bits[18:11], new_x[30:19],
  // new_y[42:31], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]   s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_offset[26:0], pixel_value[42:27], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = COORD_BITS;
  localparam int CB     = $clog2(GLYPH_COUNT);
  localparam int RB     = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam int ADDR_W = CB + RB;
  localparam int DEPTH  = GLYPH_COUNT << RB;
  localparam int BASE_W = CW + PITCH_W;
  localparam int COL_W  = CW + BPP_W;
  localparam int SUM_W  = BASE_W + 1;
  localparam logic [GDIM_W-1:0] H_LIMIT =
    GDIM_W'((MAX_GLYPH_ROWS < GLYPH_COLS) ? MAX_GLYPH_ROWS : GLYPH_COLS);

  // Input fields
  logic [ACTION_W-1:0] in_action;
  logic [CODE_W-1:0]   in_code;
  logic [ROW_W-1:0]    in_row;
  logic [BITS_W-1:0]   in_bits;
  logic [NEWXY_W-1:0]  in_x;
  logic [NEWXY_W-1:0]  in_y;

  assign in_action = s_tuser;
  assign in_code   = s_tdata[7:0];
  assign in_row    = s_tdata[10:8];
  assign in_bits   = s_tdata[18:11];
  assign in_x      = s_tdata[30:19];
  assign in_y      = s_tdata[42:31];

  // Configuration registers
  logic [PITCH_W-1:0]  row_pitch;
  logic [BPP_W-1:0]    bytes_per_pixel;
  logic [GDIM_W-1:0]   glyph_width;
  logic [GDIM_W-1:0]   glyph_height;
  logic [MARGIN_W-1:0] left_margin;
  logic [STEP_W-1:0]   line_advance;
  logic [STEP_W-1:0]   char_advance;
  logic [VALUE_W-1:0]  draw_color;

  // Control and datapath state
  state_t              state;
  state_t              state_next;
  logic [CW-1:0]       cursor_x;
  logic [CW-1:0]       cursor_y;
  logic [CB-1:0]       draw_code;
  logic [ROW_W-1:0]    row_idx;
  logic [BASE_W-1:0]   row_base;
  logic [BITS_W-1:0]   bits_left;
  logic                scan_first;
  logic                pend_valid;
  logic [OFFSET_W-1:0] pend_offset;
  logic [OFFSET_W-1:0] out_offset;
  logic [VALUE_W-1:0]  out_value;
  logic                out_last;

  // Combinational signals
  logic                in_fire;
  logic                out_free;
  logic                code_ok;
  logic                row_ok;
  logic [GDIM_W-1:0]   w_eff;
  logic [GDIM_W-1:0]   h_eff;
  logic [BITS_W-1:0]   col_mask;
  logic                draw_start;
  logic                is_newline;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BITS_W-1:0]   ram_rdata;
  logic [BITS_W-1:0]   bits_cur;
  logic [2:0]          col;
  logic                last_row;
  logic                scan_take;
  logic                push_mid;
  logic                push_last;
  logic                done_exit;
  logic [CW-1:0]       py;
  logic [CW-1:0]       px;
  logic [COL_W-1:0]    col_off;
  logic [SUM_W-1:0]    off_sum;
  logic [OFFSET_W-1:0] pix_offset;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign code_ok  = 32'(in_code) < GLYPH_COUNT;
  assign row_ok   = 32'(in_row) < MAX_GLYPH_ROWS;

  assign w_eff    = (glyph_width > GDIM_W'(GLYPH_COLS)) ? GDIM_W'(GLYPH_COLS) : glyph_width;
  assign h_eff    = (glyph_height > H_LIMIT) ? H_LIMIT : glyph_height;
  assign col_mask = BITS_W'((9'd1 << w_eff) - 9'd1);

  assign is_newline = in_code == NEWLINE_CODE;
  assign draw_start = in_fire && (in_action == ACT_DRAW) && !is_newline && code_ok
                      && (h_eff != '0) && (w_eff != '0);

  assign ram_waddr = {CB'(in_code), RB'(in_row)};
  assign ram_raddr = {draw_code, RB'(row_idx)};

  gtr_ram #(
    .WIDTH (BITS_W),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_bits),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Row bits under scan: fresh RAM data on the first cycle of a row
  assign bits_cur = scan_first ? (ram_rdata & col_mask) : bits_left;
  assign last_row = (GDIM_W'(row_idx) + GDIM_W'(1)) >= h_eff;

  // Leftmost remaining column
  always_comb begin
    col = '0;
    for (int b = BITS_W - 1; b >= 0; b--) begin
      if (bits_cur[b]) begin
        col = 3'(b);
      end
    end
  end

  // Pixel address: row base is precomputed at row fetch
  assign py         = CW'(cursor_y + CW'(row_idx));
  assign px         = CW'(cursor_x + CW'(col));
  assign col_off    = px * bytes_per_pixel;
  assign off_sum    = SUM_W'(row_base) + SUM_W'(col_off);
  assign pix_offset = OFFSET_W'(off_sum);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (draw_start) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (bits_cur == '0) begin
          state_next = last_row ? ST_DONE : ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    scan_take = 1'b0;
    push_mid  = 1'b0;
    push_last = 1'b0;
    done_exit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_FETCH: begin
        ram_re = 1'b1;
      end
      ST_SCAN: begin
        // hold the scan while the previous pixel cannot move out
        scan_take = (bits_cur != '0) && (!pend_valid || out_free);
        push_mid  = scan_take && pend_valid;
      end
      ST_DONE: begin
        push_last = pend_valid && out_free;
        done_exit = !pend_valid || out_free;
      end
      default: s_tready = 1'b0;
    endcase
  end

  assign ram_we = in_fire && (in_action == ACT_LOAD) && code_ok && row_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cursor_x        <= '0;
      cursor_y        <= '0;
      row_pitch       <= RST_ROW_PITCH;
      bytes_per_pixel <= RST_BYTES_PER_PX;
      glyph_width     <= RST_GLYPH_WIDTH;
      glyph_height    <= RST_GLYPH_HEIGHT;
      left_margin     <= RST_LEFT_MARGIN;
      line_advance    <= RST_LINE_ADVANCE;
      char_advance    <= RST_CHAR_ADVANCE;
      draw_color      <= RST_DRAW_COLOR;
      pend_valid      <= 1'b0;
      m_tvalid        <= 1'b0;
      scan_first      <= 1'b0;
      row_idx         <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_PITCH:    row_pitch       <= cfg_data[PITCH_W-1:0];
          REG_BYTES_PER_PX: bytes_per_pixel <= cfg_data[BPP_W-1:0];
          REG_GLYPH_WIDTH:  glyph_width     <= cfg_data[GDIM_W-1:0];
          REG_GLYPH_HEIGHT: glyph_height    <= cfg_data[GDIM_W-1:0];
          REG_LEFT_MARGIN:  left_margin     <= cfg_data[MARGIN_W-1:0];
          REG_LINE_ADVANCE: line_advance    <= cfg_data[STEP_W-1:0];
          REG_CHAR_ADVANCE: char_advance    <= cfg_data[STEP_W-1:0];
          REG_DRAW_COLOR:   draw_color      <= cfg_data;
          default:          draw_color      <= draw_color;
        endcase
      end

      // Cursor updates
      if (in_fire) begin
        priority if (in_action == ACT_CURSOR) begin
          cursor_x <= CW'(in_x);
          cursor_y <= CW'(in_y);
        end else if (in_action == ACT_DRAW && is_newline) begin
          cursor_x <= CW'(left_margin);
          cursor_y <= CW'(cursor_y + CW'(line_advance));
        end else if (in_action == ACT_DRAW && !draw_start) begin
          // nothing to draw: advance at once
          cursor_x <= CW'(cursor_x + CW'(char_advance));
        end else begin
          cursor_x <= cursor_x;
        end
      end else if (done_exit) begin
        cursor_x <= CW'(cursor_x + CW'(char_advance));
      end

      if (draw_start) begin
        draw_code <= CB'(in_code);
        row_idx   <= '0;
      end

      if (state == ST_FETCH) begin
        row_base   <= py * row_pitch;
        scan_first <= 1'b1;
      end

      if (state == ST_SCAN) begin
        scan_first <= 1'b0;
        if (bits_cur == '0) begin
          row_idx <= row_idx + ROW_W'(1);
        end else if (scan_take) begin
          bits_left   <= bits_cur & ~(BITS_W'(1) << col);
          pend_offset <= pix_offset;
          pend_valid  <= 1'b1;
        end else begin
          bits_left <= bits_cur;
        end
      end

      if (push_last) begin
        pend_valid <= 1'b0;
      end

      // Output register: the held pixel moves out once the next one is known or the glyph ends
      if (push_mid || push_last) begin
        m_tvalid   <= 1'b1;
        out_offset <= pend_offset;
        out_value  <= draw_color;
        out_last   <= push_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(OUT_DATA_W - OFFSET_W - VALUE_W)'(0), out_value, out_offset};
  assign m_tlast = out_last;

endmodule

### rtl/gtr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module gtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### verif/glyph_text_renderer_checker.sv
`timescale 1ns / 1ps
// Pixel write checker for the glyph text renderer: tracks glyph store, cursor
// and registers from the observed beats and compares every pixel write.
// Depends on gtr_pkg.
module glyph_text_renderer_checker
  import gtr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [ACTION_W-1:0]   s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    writes_pending,
  output int                    writes_checked
);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } pixel_write_t;

  localparam int REPORT_CAP = 40;

  logic [BITS_W-1:0]         glyph_mem [0:GTR_GLYPH_COUNT*GTR_MAX_GLYPH_ROWS-1];
  logic [GTR_COORD_BITS-1:0] cur_x, cur_y;

  logic [PITCH_W-1:0]  pitch_r;
  logic [BPP_W-1:0]    bpp_r;
  logic [GDIM_W-1:0]   width_r, height_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [STEP_W-1:0]   line_adv_r, char_adv_r;
  logic [VALUE_W-1:0]  color_r;

  pixel_write_t pixel_q[$];

  initial begin
    mismatches     = 0;
    writes_pending = 0;
    writes_checked = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("checker: %s: got %0h, expected %0h (write %0d, %0t)",
               what, got, want, writes_checked, $time);
  endtask

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ROW_PITCH:    pitch_r    = d[PITCH_W-1:0];
      REG_BYTES_PER_PX: bpp_r      = d[BPP_W-1:0];
      REG_GLYPH_WIDTH:  width_r    = d[GDIM_W-1:0];
      REG_GLYPH_HEIGHT: height_r   = d[GDIM_W-1:0];
      REG_LEFT_MARGIN:  margin_r   = d[MARGIN_W-1:0];
      REG_LINE_ADVANCE: line_adv_r = d[STEP_W-1:0];
      REG_CHAR_ADVANCE: char_adv_r = d[STEP_W-1:0];
      REG_DRAW_COLOR:   color_r    = d[VALUE_W-1:0];
      default: ;
    endcase
  endtask

  // Expand one accepted beat into the pixel writes it must produce
  task automatic render_item(input logic [ACTION_W-1:0] act, input logic [IN_DATA_W-1:0] d);
    logic [CODE_W-1:0]         code;
    logic [ROW_W-1:0]          row;
    logic [BITS_W-1:0]         bits;
    logic [NEWXY_W-1:0]        nx, ny;
    logic [BITS_W-1:0]         line;
    logic [GTR_COORD_BITS-1:0] px, py;
    longint                    full;
    int                        cols, rows, i, j;
    pixel_write_t              held;
    bit                        have_held;
    code = d[7:0];
    row  = d[10:8];
    bits = d[18:11];
    nx   = d[30:19];
    ny   = d[42:31];
    case (act)
      ACT_LOAD: glyph_mem[{code, row}] = bits;
      ACT_CURSOR: begin
        cur_x = nx;
        cur_y = ny;
      end
      ACT_DRAW: begin
        if (code == NEWLINE_CODE) begin
          cur_x = margin_r;
          cur_y = cur_y + GTR_COORD_BITS'(line_adv_r);
        end else begin
          cols = (int'(width_r) > GLYPH_COLS) ? GLYPH_COLS : int'(width_r);
          rows = (int'(height_r) > GTR_MAX_GLYPH_ROWS) ? GTR_MAX_GLYPH_ROWS : int'(height_r);
          have_held = 1'b0;
          held = '0;
          for (i = 0; i < rows; i++) begin
            line = glyph_mem[int'(code) * GTR_MAX_GLYPH_ROWS + i];
            for (j = 0; j < cols; j++) begin
              if (line[j]) begin
                // hold back one write so the final one can carry last
                if (have_held) pixel_q.push_back(held);
                px = cur_x + GTR_COORD_BITS'(j);
                py = cur_y + GTR_COORD_BITS'(i);
                full = longint'(py) * longint'(pitch_r) + longint'(px) * longint'(bpp_r);
                held.offset = full[OFFSET_W-1:0];
                held.value  = color_r;
                held.last   = 1'b0;
                have_held   = 1'b1;
              end
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            pixel_q.push_back(held);
          end
          cur_x = cur_x + GTR_COORD_BITS'(char_adv_r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_write(input logic [OUT_DATA_W-1:0] d, input logic lst);
    pixel_write_t want;
    writes_checked++;
    if (pixel_q.size() == 0) begin
      report_mismatch("pixel write with none outstanding", longint'(d), 0);
    end else begin
      want = pixel_q.pop_front();
      if (d[26:0] !== want.offset)
        report_mismatch("pixel_offset", longint'(d[26:0]), longint'(want.offset));
      if (d[42:27] !== want.value)
        report_mismatch("pixel_value", longint'(d[42:27]), longint'(want.value));
      if (lst !== want.last)
        report_mismatch("last", longint'(lst), longint'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_x      = '0;
      cur_y      = '0;
      pitch_r    = RST_ROW_PITCH;
      bpp_r      = RST_BYTES_PER_PX;
      width_r    = RST_GLYPH_WIDTH;
      height_r   = RST_GLYPH_HEIGHT;
      margin_r   = RST_LEFT_MARGIN;
      line_adv_r = RST_LINE_ADVANCE;
      char_adv_r = RST_CHAR_ADVANCE;
      color_r    = RST_DRAW_COLOR;
      pixel_q.delete();
    end else begin
      if (cfg_we) apply_config(cfg_index, cfg_data);
      if (m_tvalid && m_tready) check_write(m_tdata, m_tlast);
      if (s_tvalid && s_tready) render_item(s_tuser, s_tdata);
    end
    writes_pending = pixel_q.size();
  end

endmodule

### verif/glyph_text_renderer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the glyph text renderer: clock, reset, stimulus and
// register settings; checking is done by glyph_text_renderer_checker.
// Depends on gtr_pkg, glyph_text_renderer_top and the checker.
module glyph_text_renderer_top_tb;
  import gtr_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [ACTION_W-1:0]   s_tuser;
  logic                  m_tvalid, m_tready, m_tlast;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches, writes_pending, writes_checked;
  int draws, loads, moves, settings;
  bit quiet_tx, steady_rx;

  logic [7:0]        rows_loaded [0:GTR_GLYPH_COUNT-1];
  logic [CODE_W-1:0] ready_codes[$];

  glyph_text_renderer_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  glyph_text_renderer_checker pixel_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .writes_pending(writes_pending),
    .writes_checked(writes_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 8);
    else return $urandom_range(12, 20);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    logic [3:0] dim;
    if ($urandom_range(0, 99) < 80) dim = 4'($urandom_range(1, 8));
    else if ($urandom_range(0, 1) == 0) dim = 4'd0;
    else dim = 4'($urandom_range(9, 15));
    return {12'($urandom), dim};
  endfunction

  // Output side: ready runs broken by stalls, none while steady_rx is set
  initial begin
    int run, stall;
    m_tready <= 1'b0;
    forever begin
      m_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
      stall = steady_rx ? 0 : pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CODE_W-1:0] code,
                           input logic [ROW_W-1:0] row, input logic [BITS_W-1:0] bits,
                           input logic [NEWXY_W-1:0] nx, input logic [NEWXY_W-1:0] ny);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'd0, ny, nx, bits, row, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (act)
      ACT_DRAW:   draws++;
      ACT_CURSOR: moves++;
      ACT_LOAD: begin
        loads++;
        if (rows_loaded[code] != 8'hff) begin
          rows_loaded[code][row] = 1'b1;
          if (rows_loaded[code] == 8'hff) ready_codes.push_back(code);
        end
      end
      default: ;
    endcase
  endtask

  task automatic draw_char(input logic [CODE_W-1:0] code);
    send_item(ACT_DRAW, code, ROW_W'($urandom), BITS_W'($urandom),
              NEWXY_W'($urandom), NEWXY_W'($urandom));
  endtask

  task automatic load_glyph(input logic [CODE_W-1:0] code);
    int r;
    for (r = 0; r < GTR_MAX_GLYPH_ROWS; r++)
      send_item(ACT_LOAD, code, ROW_W'(r), BITS_W'($urandom),
                NEWXY_W'($urandom), NEWXY_W'($urandom));
  endtask

  // Drop valid and hold until every pixel write is back and the block is idle
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (writes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] pitch, input logic [CFG_DATA_W-1:0] bpp,
                               input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] margin,
                               input logic [CFG_DATA_W-1:0] line_adv,
                               input logic [CFG_DATA_W-1:0] char_adv,
                               input logic [CFG_DATA_W-1:0] color);
    write_reg(REG_ROW_PITCH, pitch);
    write_reg(REG_BYTES_PER_PX, bpp);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_LEFT_MARGIN, margin);
    write_reg(REG_LINE_ADVANCE, line_adv);
    write_reg(REG_CHAR_ADVANCE, char_adv);
    write_reg(REG_DRAW_COLOR, color);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_setting();
    apply_setting(16'($urandom), {13'($urandom), 3'($urandom_range(0, 7))},
                  pick_dim(), pick_dim(), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
  endtask

  task automatic run_phase(input int target);
    int                done, pick, reps;
    logic [CODE_W-1:0] code;
    logic [NEWXY_W-1:0] nx, ny;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // fresh glyph followed by a few draws of it
        code = CODE_W'($urandom);
        load_glyph(code);
        reps = $urandom_range(1, 3);
        repeat (reps) draw_char(code);
        done += GTR_MAX_GLYPH_ROWS + reps;
      end else if (pick < 62 && ready_codes.size() > 0) begin
        draw_char(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
        done++;
      end else if (pick < 72) begin
        draw_char(NEWLINE_CODE);
        done++;
      end else if (pick < 82) begin
        nx = ($urandom_range(0, 2) == 0) ? NEWXY_W'($urandom_range(4080, 4095))
                                         : NEWXY_W'($urandom);
        ny = ($urandom_range(0, 2) == 0) ? NEWXY_W'($urandom_range(4080, 4095))
                                         : NEWXY_W'($urandom);
        send_item(ACT_CURSOR, CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom),
                  nx, ny);
        done++;
      end else if (pick < 92) begin
        send_item(ACT_LOAD, CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom),
                  NEWXY_W'($urandom), NEWXY_W'($urandom));
        done++;
      end else begin
        send_item(ACT_UNUSED, CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom),
                  NEWXY_W'($urandom), NEWXY_W'($urandom));
      end
    end
  endtask

  initial begin
    int r;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= ACT_DRAW;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ROW_PITCH;
    cfg_data  <= '0;
    quiet_tx  = 1'b0;
    steady_rx = 1'b0;
    draws = 0;
    loads = 0;
    moves = 0;
    settings = 0;
    for (r = 0; r < GTR_GLYPH_COUNT; r++) rows_loaded[r] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full glyph at the top code, empty glyph at code zero
    for (r = 0; r < GTR_MAX_GLYPH_ROWS; r++)
      send_item(ACT_LOAD, 8'hff, ROW_W'(r), 8'hff, 12'h000, 12'h000);
    for (r = 0; r < GTR_MAX_GLYPH_ROWS; r++)
      send_item(ACT_LOAD, 8'h00, ROW_W'(r), 8'h00, 12'hfff, 12'hfff);
    // full glyph at the far corner wraps in both coordinates
    send_item(ACT_CURSOR, 8'h00, 3'd0, 8'h00, 12'hfff, 12'hfff);
    draw_char(8'hff);
    draw_char(8'h00);
    draw_char(NEWLINE_CODE);
    send_item(ACT_CURSOR, 8'hff, 3'd7, 8'hff, 12'h000, 12'h000);
    draw_char(8'hff);
    send_item(ACT_UNUSED, 8'hff, 3'd7, 8'hff, 12'hfff, 12'hfff);
    draw_char(NEWLINE_CODE);
    draw_char(8'hff);
    run_phase(35);

    // widest values: clamped glyph size, largest offsets
    drain_pixels();
    apply_setting(16'h3fff, 16'd7, 16'd15, 16'd15, 16'd4095, 16'd255, 16'd255, 16'hffff);
    run_phase(35);

    // all zero: nothing drawn, cursor beats still move the cursor
    drain_pixels();
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(15);

    // back-to-back traffic with no stalls on either side
    drain_pixels();
    random_setting();
    quiet_tx  = 1'b1;
    steady_rx = 1'b1;
    run_phase(40);
    quiet_tx  = 1'b0;
    steady_rx = 1'b0;

    repeat (3) begin
      drain_pixels();
      random_setting();
      run_phase(40);
    end

    drain_pixels();
    $display("summary: %0d draws, %0d glyph row loads, %0d cursor moves, %0d register settings",
             draws, loads, moves, settings);
    $display("summary: %0d pixel write beats compared, %0d mismatches",
             writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gtr_pkg.sv
rtl/gtr_ram.sv
rtl/glyph_text_renderer_top.sv
verif/glyph_text_renderer_checker.sv
verif/glyph_text_renderer_top_tb.sv
